// File: rtl/core/stt_pkg.sv
// Shared types, codes and defaults for the software timer table.
package stt_pkg;

   localparam int MAX_TASKS_DEF = 8;

   // Request commands
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_STOP  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NOT_ENABLED = 3'd1;
   localparam logic [2:0] ST_FULL        = 3'd2;
   localparam logic [2:0] ST_NULL_TASK   = 3'd3;
   localparam logic [2:0] ST_EMPTY       = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd5;

   // Configuration register indexes
   localparam logic REG_ENABLED    = 1'b0;
   localparam logic REG_RESOLUTION = 1'b1;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] delay;
      logic        periodic;
      logic [15:0] elapsed;
   } entry_type;

   // Per-cycle command to every cell of the row
   typedef struct packed {
      logic append;   // load the new entry into the first free cell
      logic step;     // one scan step at the head of the row
      logic remove;   // the head entry leaves the table in this step
   } cell_ctl_type;

endpackage

// File: rtl/core/stt_cell.sv
// One timer entry cell of the table row.
module stt_cell import stt_pkg::*; #(
   parameter int CNT_W = 4,
   parameter int K     = 0
) (
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic [CNT_W-1:0] cnt,
   input  logic [CNT_W-1:0] rem,
   input  entry_type        new_entry,
   input  entry_type        nxt,
   input  entry_type        tail,
   input  entry_type        head_keep,
   output entry_type        entry
);

   localparam logic [CNT_W-1:0] K0 = CNT_W'(K);
   localparam logic [CNT_W-1:0] K1 = CNT_W'(K + 1);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.append && cnt == K0) begin
         entry_in = new_entry;
      end else if (ctl.step) begin
         if (!ctl.remove) begin
            // rotate the active ring; the kept head wraps to the end
            if (K1 == cnt) begin
               entry_in = head_keep;
            end else if (K1 < cnt) begin
               entry_in = nxt;
            end
         end else begin
            // last unscanned entry fills the head; processed part closes up
            if (K == 0 && rem > CNT_W'(1)) begin
               entry_in = tail;
            end else if (K1 >= rem && K1 < cnt) begin
               entry_in = nxt;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: rtl/core/software_timer_table.sv
// Top level of the software timer table: request decode, scan control and results.
//
// Usage:
//   Requests enter on req_* and are taken at a clock edge where start is high
//   and busy is low. A start (append an entry) or stop on an empty table, a
//   base tick that does not dispatch, and an unused command give one result in
//   the cycle after acceptance and leave busy low, so the next request can be
//   taken at once. A stop on a non-empty table, and a base tick that reaches
//   the resolution, scan the table one entry per cycle; busy stays high through
//   the scan and a flush step. A dispatch gives one result per fired entry, in
//   table order (one with no fired id if none fires), each on rsp_* for one
//   cycle with rsp_valid high; rsp_last marks the final result of the request.
//   The receiver cannot stall: results are not held. The csr_* channel writes
//   enabled (index 0) and resolution (index 1); it is always ready. The user
//   must write it only while busy is low; the block does not enforce this.
//   Reset (synchronous, active high) empties the table, clears the base tick
//   count, sets enabled to 0 and resolution to 1. Entries live in a row of
//   cells; each scan step rotates the row by one, or on a removal brings the
//   last unscanned entry up; the entry under test is always in the head cell.
module software_timer_table import stt_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_task_id,
   input  logic [15:0] req_delay_ticks,
   input  logic        req_periodic,
   // result channel
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic        rsp_fired_valid,
   output logic [7:0]  rsp_fired_id,
   output logic        rsp_last,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [15:0]      base_ff, base_in;
   logic             enabled_ff, enabled_in;
   logic [15:0]      res_ff, res_in;
   logic             tick_mode_ff, tick_mode_in;
   logic [7:0]       sid_ff, sid_in;
   logic             found_ff, found_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [7:0]       pend_id_ff, pend_id_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_fv_ff, rsp_fv_in;
   logic [7:0]       rsp_id_ff, rsp_id_in;
   logic             rsp_last_ff, rsp_last_in;

   cell_ctl_type     ctl;
   entry_type        new_entry;
   entry_type        cell_q [MAX_TASKS];
   entry_type        tail;
   entry_type        head;
   entry_type        head_keep;
   logic [15:0]      elapsed_inc;
   logic             fire;
   logic             match;
   logic             remove;
   logic             accept;
   logic [15:0]      tick_next;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // row of entry cells
   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
      entry_type nxt;
      if (g == MAX_TASKS - 1) begin : g_end
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = cell_q[g + 1];
      end
      stt_cell #(
         .CNT_W (CNT_W),
         .K     (g)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .cnt       (cnt_ff),
         .rem       (rem_ff),
         .new_entry (new_entry),
         .nxt       (nxt),
         .tail      (tail),
         .head_keep (head_keep),
         .entry     (cell_q[g])
      );
   end

   // last unscanned entry: the cell just below the remaining count
   always_comb begin
      tail = '0;
      for (int k = 0; k < MAX_TASKS; k++) begin
         if (CNT_W'(k + 1) == rem_ff) begin
            tail = cell_q[k];
         end
      end
   end

   // head cell test: a dispatch advances elapsed and fires on equality,
   // a stop drops entries that carry the requested id
   assign head        = cell_q[0];
   assign elapsed_inc = head.elapsed + 16'd1;
   assign fire        = tick_mode_ff && (elapsed_inc == head.delay);
   assign match       = !tick_mode_ff && (head.id == sid_ff);
   assign remove      = tick_mode_ff ? (fire && !head.periodic) : match;

   always_comb begin
      head_keep = head;
      if (tick_mode_ff) begin
         head_keep.elapsed = fire ? 16'd0 : elapsed_inc;
      end
   end

   assign new_entry = '{id: req_task_id, delay: req_delay_ticks,
                        periodic: req_periodic, elapsed: 16'd0};
   assign tick_next = base_ff + 16'd1;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      base_in       = base_ff;
      enabled_in    = enabled_ff;
      res_in        = res_ff;
      tick_mode_in  = tick_mode_ff;
      sid_in        = sid_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      ctl           = '0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_fv_in     = 1'b0;
      rsp_id_in     = 8'd0;
      rsp_last_in   = 1'b1;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ENABLED:    enabled_in = csr_data[0];
            REG_RESOLUTION: res_in     = csr_data;
            default:        ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               unique case (req_cmd)
                  CMD_START: begin
                     if (!enabled_ff) begin
                        rsp_status_in = ST_NOT_ENABLED;
                     end else if (cnt_ff == CNT_W'(MAX_TASKS)) begin
                        rsp_status_in = ST_FULL;
                     end else if (req_task_id == 8'd0) begin
                        rsp_status_in = ST_NULL_TASK;
                     end else begin
                        ctl.append = 1'b1;
                        cnt_in     = cnt_ff + CNT_W'(1);
                     end
                  end
                  CMD_STOP: begin
                     if (cnt_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        // hold the result until the scan ends
                        rsp_valid_in = 1'b0;
                        tick_mode_in = 1'b0;
                        sid_in       = req_task_id;
                        found_in     = 1'b0;
                        rem_in       = cnt_ff;
                        state_in     = S_SCAN;
                     end
                  end
                  CMD_TICK: begin
                     if (cnt_ff != '0) begin
                        if (tick_next == res_ff) begin
                           base_in       = 16'd0;
                           rsp_valid_in  = 1'b0;
                           tick_mode_in  = 1'b1;
                           pend_valid_in = 1'b0;
                           rem_in        = cnt_ff;
                           state_in      = S_SCAN;
                        end else begin
                           base_in = tick_next;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            ctl.step   = 1'b1;
            ctl.remove = remove;
            rem_in     = rem_ff - CNT_W'(1);
            if (remove) begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
            if (match) begin
               found_in = 1'b1;
            end
            // a fired entry is held as pending until the next fire or the flush, so that the final one can carry last
            if (fire) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_fv_in    = 1'b1;
                  rsp_id_in    = pend_id_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_id_in    = head.id;
            end
            if (rem_ff == CNT_W'(1)) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            rsp_valid_in = 1'b1;
            if (tick_mode_ff) begin
               rsp_fv_in = pend_valid_ff;
               rsp_id_in = pend_valid_ff ? pend_id_ff : 8'd0;
            end else begin
               rsp_status_in = found_ff ? ST_OK : ST_NOT_FOUND;
            end
            pend_valid_in = 1'b0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rem_ff        <= '0;
         base_ff       <= 16'd0;
         enabled_ff    <= 1'b0;
         res_ff        <= 16'd1;
         tick_mode_ff  <= 1'b0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rem_ff        <= rem_in;
         base_ff       <= base_in;
         enabled_ff    <= enabled_in;
         res_ff        <= res_in;
         tick_mode_ff  <= tick_mode_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sid_ff        <= sid_in;
      pend_id_ff    <= pend_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fv_ff     <= rsp_fv_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_fired_valid = rsp_fv_ff;
   assign rsp_fired_id    = rsp_id_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_TASKS))
      else $error("active count above table size");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> (rem_ff != '0 && rem_ff <= cnt_ff))
      else $error("scan remainder out of range");

   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLUSH |=> (rsp_valid && rsp_last))
      else $error("final result missing after scan");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final result outside a scan");
`endif

endmodule

// File: bench/timer_table_checker.sv
// Result checker for the software timer table: tracks the timer entries and compares results.
`timescale 1ns / 1ps

module timer_table_checker import stt_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_task_id,
   input  logic [15:0] req_delay_ticks,
   input  logic        req_periodic,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_status,
   input  logic        rsp_fired_valid,
   input  logic [7:0]  rsp_fired_id,
   input  logic        rsp_last,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   output int          error_count,
   output int          pending
);

   typedef struct packed {
      logic [2:0] status;
      logic       fired_valid;
      logic [7:0] fired_id;
      logic       last;
   } timer_rsp_type;

   timer_rsp_type due_rsps[$];
   entry_type     slot[MAX_TASKS];
   int            used;
   logic [15:0]   tick_count;
   logic          enabled_q;
   logic [15:0]   resolution_q;

   function void queue_rsp(logic [2:0] st, logic fv, logic [7:0] fid, logic lst);
      timer_rsp_type r;
      r.status      = st;
      r.fired_valid = fv;
      r.fired_id    = fid;
      r.last        = lst;
      due_rsps.push_back(r);
   endfunction

   // Fill slot i with the last active entry and shrink the table.
   function void drop_slot(int i);
      slot[i]        = slot[used - 1];
      slot[used - 1] = '0;
      used--;
   endfunction

   function void apply_request(logic [1:0] cmd, logic [7:0] t_id, logic [15:0] dly,
                               logic per);
      int            i;
      int            fired;
      logic          found;
      timer_rsp_type r;
      fired = 0;
      case (cmd)
         CMD_START: begin
            if (!enabled_q) begin
               queue_rsp(ST_NOT_ENABLED, 1'b0, 8'd0, 1'b1);
            end else if (used >= MAX_TASKS) begin
               queue_rsp(ST_FULL, 1'b0, 8'd0, 1'b1);
            end else if (t_id == 8'd0) begin
               queue_rsp(ST_NULL_TASK, 1'b0, 8'd0, 1'b1);
            end else begin
               slot[used].id       = t_id;
               slot[used].delay    = dly;
               slot[used].periodic = per;
               slot[used].elapsed  = 16'd0;
               used++;
               queue_rsp(ST_OK, 1'b0, 8'd0, 1'b1);
            end
         end
         CMD_STOP: begin
            if (used == 0) begin
               queue_rsp(ST_EMPTY, 1'b0, 8'd0, 1'b1);
            end else begin
               found = 1'b0;
               i = 0;
               // the refilled slot is looked at again
               while (i < used) begin
                  if (slot[i].id == t_id) begin
                     found = 1'b1;
                     drop_slot(i);
                  end else begin
                     i++;
                  end
               end
               queue_rsp(found ? ST_OK : ST_NOT_FOUND, 1'b0, 8'd0, 1'b1);
            end
         end
         CMD_TICK: begin
            if (used != 0) begin
               tick_count = tick_count + 16'd1;
               if (tick_count == resolution_q) begin
                  tick_count = 16'd0;
                  for (i = 0; i < used; i++) slot[i].elapsed = slot[i].elapsed + 16'd1;
                  i = 0;
                  while (i < used) begin
                     if (slot[i].elapsed == slot[i].delay) begin
                        slot[i].elapsed = 16'd0;
                        queue_rsp(ST_OK, 1'b1, slot[i].id, 1'b0);
                        fired++;
                        if (!slot[i].periodic) begin
                           drop_slot(i);
                           continue;
                        end
                     end
                     i++;
                  end
               end
            end
         end
         default: ;
      endcase
      if (cmd == CMD_TICK) begin
         if (fired == 0) begin
            queue_rsp(ST_OK, 1'b0, 8'd0, 1'b1);
         end else begin
            r = due_rsps.pop_back();
            r.last = 1'b1;
            due_rsps.push_back(r);
         end
      end else if (cmd != CMD_START && cmd != CMD_STOP) begin
         queue_rsp(ST_OK, 1'b0, 8'd0, 1'b1);
      end
   endfunction

   always @(posedge clock) begin : watch
      timer_rsp_type got;
      timer_rsp_type want;
      if (reset) begin
         for (int j = 0; j < MAX_TASKS; j++) slot[j] = '0;
         used         = 0;
         tick_count   = 16'd0;
         enabled_q    = 1'b0;
         resolution_q = 16'd1;
         due_rsps.delete();
      end else begin
         if (rsp_valid) begin
            got.status      = rsp_status;
            got.fired_valid = rsp_fired_valid;
            got.fired_id    = rsp_fired_id;
            got.last        = rsp_last;
            if (due_rsps.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: unexpected result status=%0d fired=%0d id=%0d last=%0d",
                           $time, got.status, got.fired_valid, got.fired_id, got.last);
               error_count++;
            end else begin
               want = due_rsps.pop_front();
               if (got.status != want.status || got.fired_valid != want.fired_valid ||
                   got.fired_id != want.fired_id || got.last != want.last) begin
                  if (error_count < 10)
                     $display("%0t: result mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                              $time, want.status, want.fired_valid, want.fired_id, want.last,
                              got.status, got.fired_valid, got.fired_id, got.last);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ENABLED:    enabled_q = csr_data[0];
               REG_RESOLUTION: resolution_q = csr_data;
               default: ;
            endcase
         end
         if (start && !busy)
            apply_request(req_cmd, req_task_id, req_delay_ticks, req_periodic);
      end
      pending = due_rsps.size();
   end

endmodule

// File: bench/software_timer_table_test.sv
// Testbench top for the software timer table: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps

module software_timer_table_test;
   import stt_pkg::*;

   localparam int         MAX_TASKS   = MAX_TASKS_DEF;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   // watchdog limit, set with a wide margin over a full pass
   localparam int         CYCLE_LIMIT = 50_000;
   // idle wait at the end of settle(), longer than a full scan of the table
   localparam int         SETTLE      = MAX_TASKS + 4;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd = CMD_TICK;
   logic [7:0]  req_task_id = 8'd0;
   logic [15:0] req_delay_ticks = 16'd0;
   logic        req_periodic = 1'b0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic        rsp_fired_valid;
   logic [7:0]  rsp_fired_id;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = REG_ENABLED;
   logic [15:0] csr_data = 16'd0;

   int error_count;
   int pending;
   int cycles = 0;
   bit idle_en = 1'b1;

   software_timer_table #(.MAX_TASKS(MAX_TASKS)) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_task_id     (req_task_id),
      .req_delay_ticks (req_delay_ticks),
      .req_periodic    (req_periodic),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_fired_valid (rsp_fired_valid),
      .rsp_fired_id    (rsp_fired_id),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   timer_table_checker #(.MAX_TASKS(MAX_TASKS)) u_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_task_id     (req_task_id),
      .req_delay_ticks (req_delay_ticks),
      .req_periodic    (req_periodic),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_fired_valid (rsp_fired_valid),
      .rsp_fired_id    (rsp_fired_id),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .error_count     (error_count),
      .pending         (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if the block hangs or drops results.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Present one item at a falling edge and hold it until the block takes it.
   // Insert random idle cycles first so gaps land on every phase of a scan.
   task automatic send(input logic [1:0] cmd, input logic [7:0] t_id,
                       input logic [15:0] dly, input logic per);
      while (idle_en && $urandom_range(0, 99) < 16) begin
         start = 1'b0;
         @(negedge clock);
      end
      start           = 1'b1;
      req_cmd         = cmd;
      req_task_id     = t_id;
      req_delay_ticks = dly;
      req_periodic    = per;
      do begin
         @(posedge clock);
      end while (busy);
      @(negedge clock);
   endtask

   // Drop start and hold off until every awaited result is in and the block is idle.
   task automatic settle();
      start = 1'b0;
      @(negedge clock);
      while (pending != 0 || busy) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Registers change only while the block is idle: drain first, then write both.
   task automatic configure(input logic en, input logic [15:0] res);
      settle();
      write_reg(REG_ENABLED, {15'd0, en});
      write_reg(REG_RESOLUTION, res);
   endtask

   // Mostly well-formed traffic on a small id pool so stops find entries,
   // duplicates pile up and the table fills; a few full-range ids and delays.
   task automatic random_items(input int count);
      int          pick;
      logic [7:0]  t_id;
      logic [15:0] dly;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         t_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
         dly  = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(1, 5));
         if (pick < 30)
            send(CMD_START, t_id, dly, 1'($urandom));
         else if (pick < 45)
            send(CMD_STOP, t_id, 16'($urandom), 1'($urandom));
         else if (pick < 95)
            send(CMD_TICK, 8'($urandom), 16'($urandom), 1'($urandom));
         else
            send(CMD_UNUSED, 8'($urandom), 16'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      int k;

      // Hold reset, then release it at a falling edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Out of reset the block is disabled: start is refused, stop finds an
      // empty table, tick and the unused command are ignored.
      send(CMD_START, 8'd5, 16'd3, 1'b1);
      send(CMD_STOP, 8'd5, 16'd0, 1'b0);
      send(CMD_TICK, 8'd0, 16'd0, 1'b0);
      send(CMD_UNUSED, 8'hFF, 16'hFFFF, 1'b1);

      configure(1'b1, 16'd1);
      send(CMD_START, 8'd0, 16'd4, 1'b0);      // null task id
      send(CMD_START, 8'hFF, 16'd1, 1'b0);     // one-shot, fires on first dispatch
      send(CMD_START, 8'd7, 16'd2, 1'b1);
      send(CMD_START, 8'd7, 16'd1, 1'b1);      // duplicate id gets its own entry
      send(CMD_START, 8'd9, 16'd0, 1'b0);      // zero delay waits for elapsed to wrap
      for (k = 1; k <= 4; k++) send(CMD_START, 8'(k), 16'hFFFF, 1'b1);
      send(CMD_START, 8'd10, 16'd1, 1'b0);     // table full
      // First dispatch: the one-shot goes and the entry moved into its slot is
      // scanned in the same pass.
      send(CMD_TICK, 8'd0, 16'd0, 1'b0);
      send(CMD_TICK, 8'd0, 16'd0, 1'b0);
      send(CMD_STOP, 8'd7, 16'd0, 1'b0);       // both duplicates leave
      send(CMD_STOP, 8'd200, 16'd0, 1'b0);     // no match

      // Disabling clears nothing: stop still works, ticks still dispatch.
      configure(1'b0, 16'd1);
      send(CMD_STOP, 8'd1, 16'd0, 1'b0);
      send(CMD_START, 8'd11, 16'd1, 1'b1);
      send(CMD_TICK, 8'd0, 16'd0, 1'b0);

      // Empty the table, then start a lone zero-delay one-shot: it stays
      // quiet through the four dispatches that follow.
      configure(1'b1, 16'd1);
      send(CMD_STOP, 8'd2, 16'd0, 1'b0);
      send(CMD_STOP, 8'd3, 16'd0, 1'b0);
      send(CMD_STOP, 8'd4, 16'd0, 1'b0);
      send(CMD_STOP, 8'd9, 16'd0, 1'b0);
      send(CMD_START, 8'd9, 16'd0, 1'b0);
      repeat (4) send(CMD_TICK, 8'd0, 16'd0, 1'b0);

      // Advance the base count part way, then lower the resolution to the
      // next count value: the following tick dispatches.
      configure(1'b1, 16'd5);
      send(CMD_START, 8'd20, 16'd1, 1'b1);
      repeat (3) send(CMD_TICK, 8'd0, 16'd0, 1'b0);
      configure(1'b1, 16'd4);
      send(CMD_TICK, 8'd0, 16'd0, 1'b0);
      send(CMD_STOP, 8'd20, 16'd0, 1'b0);
      send(CMD_STOP, 8'd9, 16'd0, 1'b0);

      // Random traffic in phases, with a register change between phases.
      configure(1'b1, 16'd1);
      random_items(20);
      configure(1'b1, 16'd2);
      idle_en = 1'b0;                          // back-to-back items for a while
      random_items(20);
      idle_en = 1'b1;
      configure(1'b0, 16'd1);
      random_items(8);
      configure(1'b1, 16'($urandom_range(1, 3)));
      random_items(20);

      settle();
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
